// File: rtl/ale_pkg.sv
// shared types and codes for the array list engine
package ale_pkg;

	localparam int WORD_W = 32;
	localparam int FIELD_W = 9;
	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;
	localparam int IN_TDATA_W = 56;
	localparam int OUT_TDATA_W = 56;

	// request codes
	localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_EXTRACT = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	// what every cell does with the current command
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_UP,
		CELL_DOWN,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [WORD_W-1:0]   value;
	} cell_cmd_t;

endpackage

// File: rtl/array_list_engine_core.sv
// array list engine top level: request sequencer and chain of storage cells
//
// Holds an ordered list of up to DEPTH signed 32-bit words in a row of DEPTH
// cells, each cell one list entry, with a fill count in the sequencer. One
// request word in gives exactly one result word out. Cells move data only to
// their neighbors: an insert or append shifts every cell above the target up at
// once, a delete shifts the cells from the start position down once per removed
// entry, and extract and search rotate the whole ring once past the head cell,
// which is the only place a stored word is read; extract then shifts down once
// more. Rejected requests go straight to the finish state. A request is taken
// only while the sequencer is idle, but a finished result waits in the output
// register, so the next request is taken while the downstream side stalls.
// There is no clearing pass after reset; cells at or beyond the fill count are
// never read.
module array_list_engine_core #(
	parameter int DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // position_in[8:0], run_length[17:9], value_in[49:18], zero fill
	input  logic [2:0]  s_tuser,   // action[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // value_out[31:0], found_at[40:32], size_out[49:41], zero fill
	output logic [1:0]  m_tuser    // status[1:0]
);

	// count width holds DEPTH itself; compare width also covers the 9-bit fields
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > ale_pkg::FIELD_W) ? CW : ale_pkg::FIELD_W;

	ale_pkg::cell_cmd_t           cmd;
	logic [XW-1:0]                cell_pos;
	logic [ale_pkg::WORD_W-1:0]   cell_word [DEPTH];

	// sequencer: decodes requests, keeps the fill count, drives the chain
	ale_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW),
		.XW    (XW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.head_word (cell_word[0]),
		.cmd       (cmd),
		.cell_pos  (cell_pos)
	);

	// the cells form a ring: up shifts pull from the lower neighbor, down
	// shifts and rotation pull from the upper one, the top wraps to the head
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		ale_cell #(
			.IDX (g),
			.XW  (XW)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.pos       (cell_pos),
			.from_up   (cell_word[(g + DEPTH - 1) % DEPTH]),
			.from_down (cell_word[(g + 1) % DEPTH]),
			.word      (cell_word[g])
		);
	end

endmodule

// File: rtl/ale_cell.sv
// one storage cell of the list chain
module ale_cell #(
	parameter int IDX = 0,
	parameter int XW = 9
) (
	input  logic                        clk,
	input  ale_pkg::cell_cmd_t          cmd,
	input  logic [XW-1:0]               pos,
	input  logic [ale_pkg::WORD_W-1:0]  from_up,
	input  logic [ale_pkg::WORD_W-1:0]  from_down,
	output logic [ale_pkg::WORD_W-1:0]  word
);

	localparam logic [XW-1:0] MY_IDX = XW'(IDX);

	logic [ale_pkg::WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			ale_pkg::CELL_UP: begin
				if (MY_IDX > pos) begin
					word_q <= from_up;
				end else if (MY_IDX == pos) begin
					word_q <= cmd.value;
				end
			end
			ale_pkg::CELL_DOWN: begin
				if (MY_IDX >= pos) begin
					word_q <= from_down;
				end
			end
			ale_pkg::CELL_ROT: begin
				word_q <= from_down;
			end
			default: begin
			end
		endcase
	end

	assign word = word_q;

endmodule

// File: rtl/ale_ctrl.sv
// request sequencer: fill count, chain commands and the result register
module ale_ctrl #(
	parameter int DEPTH = 256,
	parameter int CW = 9,
	parameter int XW = 9
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ale_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [ale_pkg::ACTION_W-1:0]    s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ale_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [ale_pkg::STATUS_W-1:0]    m_tuser,
	input  logic [ale_pkg::WORD_W-1:0]      head_word,
	output ale_pkg::cell_cmd_t              cmd,
	output logic [XW-1:0]                   cell_pos
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP,
		ST_SCAN,
		ST_DOWN,
		ST_FIN
	} state_t;

	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [XW-1:0] LAST_IDX = XW'(DEPTH - 1);
	localparam logic [XW-1:0] ONE_X = XW'(1);

	state_t                          state_q;
	logic [ale_pkg::ACTION_W-1:0]    action_q;
	logic [XW-1:0]                   pos_q;
	logic [XW-1:0]                   cnt_q;
	logic [ale_pkg::WORD_W-1:0]      val_q;
	logic [CW-1:0]                   fill_q;
	logic [ale_pkg::STATUS_W-1:0]    status_q;
	logic [ale_pkg::WORD_W-1:0]      vout_q;
	logic [XW-1:0]                   found_q;
	logic                            found_v_q;

	logic [XW-1:0]                   in_pos;
	logic [XW-1:0]                   in_run;
	logic [XW-1:0]                   fill_x;
	logic                            is_full;
	logic                            s_accept;
	logic [ale_pkg::FIELD_W-1:0]     found_out;

	assign in_pos = XW'(s_tdata[8:0]);
	assign in_run = XW'(s_tdata[17:9]);
	assign fill_x = XW'(fill_q);
	assign is_full = (fill_q == FULL_CNT);
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign found_out = found_v_q ? found_q[ale_pkg::FIELD_W-1:0] : '1;

	always_comb begin
		cmd.value = val_q;
		unique case (state_q)
			ST_UP:   cmd.op = ale_pkg::CELL_UP;
			ST_SCAN: cmd.op = ale_pkg::CELL_ROT;
			ST_DOWN: cmd.op = ale_pkg::CELL_DOWN;
			default: cmd.op = ale_pkg::CELL_HOLD;
		endcase
	end

	assign cell_pos = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tuser <= '0;
			action_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
			val_q <= '0;
			status_q <= '0;
			vout_q <= '0;
			found_q <= '0;
			found_v_q <= 1'b0;
		end else begin
			// the finish state reloads the output register itself
			if (m_tvalid && m_tready && state_q != ST_FIN) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						action_q <= s_tuser;
						pos_q <= in_pos;
						val_q <= s_tdata[49:18];
						status_q <= ale_pkg::STAT_OK;
						vout_q <= '0;
						found_v_q <= 1'b0;
						cnt_q <= '0;
						unique case (s_tuser)
							ale_pkg::ACT_APPEND: begin
								if (is_full) begin
									status_q <= ale_pkg::STAT_FULL;
									state_q <= ST_FIN;
								end else begin
									pos_q <= fill_x;
									fill_q <= fill_q + 1'b1;
									state_q <= ST_UP;
								end
							end
							ale_pkg::ACT_INSERT: begin
								if (in_pos > fill_x) begin
									status_q <= ale_pkg::STAT_RANGE;
									state_q <= ST_FIN;
								end else if (is_full) begin
									status_q <= ale_pkg::STAT_FULL;
									state_q <= ST_FIN;
								end else begin
									fill_q <= fill_q + 1'b1;
									state_q <= ST_UP;
								end
							end
							ale_pkg::ACT_EXTRACT: begin
								if (in_pos >= fill_x) begin
									status_q <= ale_pkg::STAT_RANGE;
									vout_q <= '1;
									state_q <= ST_FIN;
								end else begin
									fill_q <= fill_q - 1'b1;
									state_q <= ST_SCAN;
								end
							end
							ale_pkg::ACT_DELETE: begin
								if (in_pos > fill_x || in_run > fill_x - in_pos) begin
									status_q <= ale_pkg::STAT_RANGE;
									state_q <= ST_FIN;
								end else begin
									fill_q <= fill_q - CW'(in_run);
									cnt_q <= in_run;
									state_q <= (in_run == '0) ? ST_FIN : ST_DOWN;
								end
							end
							ale_pkg::ACT_SEARCH: begin
								state_q <= ST_SCAN;
							end
							default: begin
								status_q <= ale_pkg::STAT_RANGE;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_UP: begin
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					// cnt_q is the list index sitting in the head cell this cycle
					if (action_q == ale_pkg::ACT_EXTRACT && cnt_q == pos_q) begin
						vout_q <= head_word;
					end
					if (action_q == ale_pkg::ACT_SEARCH && !found_v_q && cnt_q < fill_x
							&& head_word == val_q) begin
						found_v_q <= 1'b1;
						found_q <= cnt_q;
					end
					if (cnt_q == LAST_IDX) begin
						if (action_q == ale_pkg::ACT_EXTRACT) begin
							cnt_q <= ONE_X;
							state_q <= ST_DOWN;
						end else begin
							state_q <= ST_FIN;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DOWN: begin
					if (cnt_q == ONE_X) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tuser <= status_q;
						m_tdata <= {6'd0, ale_pkg::FIELD_W'(fill_q), found_out, vout_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond depth");

	a_fill_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!s_accept |=> $stable(fill_q))
		else $error("fill count moved without a request");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside finish state");

	a_found_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		found_v_q |-> found_q < fill_x)
		else $error("search hit beyond list end");

endmodule

// File: tb/sv/array_list_engine_core_tb.sv
// self-checking testbench for the array list engine: directed and random requests against a list model
module array_list_engine_core_tb;
	import ale_pkg::*;

	localparam int DEPTH = 256;
	localparam int CLK_PERIOD = 12;
	localparam int DIRECTED_WORDS = 25;
	localparam int RANDOM_WORDS = 1525;
	// slowest word rotates all DEPTH cells, plus stalls; the limit covers that several times over
	localparam int RUN_LIMIT = CLK_PERIOD * 2_500_000;
	localparam int FIELD_TOP = (1 << FIELD_W) - 1;

	// action codes the block rejects
	localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
	// found_at when nothing matched or no search was asked
	localparam logic [FIELD_W-1:0] NOT_FOUND = '1;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [FIELD_W-1:0]  position;
		logic [FIELD_W-1:0]  run;
		logic [WORD_W-1:0]   value;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   value;
		logic [FIELD_W-1:0]  found;
		logic [FIELD_W-1:0]  size;
	} outcome_t;

	// where the random requests push the fill count
	typedef enum {GROWING, SHRINKING, WANDERING} drift_t;

	// list model plus the queue of outcomes still owed by the block
	class list_tracker;
		logic [WORD_W-1:0] words[$];
		outcome_t awaited[$];
		int errors;

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		// apply one accepted request to the list and queue the outcome it owes
		function void note_request(request_t rq);
			outcome_t ex;
			int n, p, r, i;
			bit hit;
			n = words.size();
			p = rq.position;
			r = rq.run;
			hit = 1'b0;
			ex.status = STAT_OK;
			ex.value = '0;
			ex.found = NOT_FOUND;
			case (rq.action)
				ACT_APPEND: begin
					if (n >= DEPTH)
						ex.status = STAT_FULL;
					else
						words.push_back(rq.value);
				end
				ACT_INSERT: begin
					// a bad index wins over a full list
					if (p > n)
						ex.status = STAT_RANGE;
					else if (n >= DEPTH)
						ex.status = STAT_FULL;
					else
						words.insert(p, rq.value);
				end
				ACT_EXTRACT: begin
					if (p >= n) begin
						ex.status = STAT_RANGE;
						ex.value = '1;
					end else begin
						ex.value = words[p];
						words.delete(p);
					end
				end
				ACT_DELETE: begin
					// a zero-length run anywhere up to the fill count is fine
					if (p > n || r > n - p)
						ex.status = STAT_RANGE;
					else
						repeat (r) words.delete(p);
				end
				ACT_SEARCH: begin
					for (i = 0; i < n; i++) begin
						if (!hit && words[i] == rq.value) begin
							ex.found = FIELD_W'(i);
							hit = 1'b1;
						end
					end
				end
				default: ex.status = STAT_RANGE;
			endcase
			ex.size = FIELD_W'(words.size());
			awaited.push_back(ex);
		endfunction

		// compare one result word with the oldest owed outcome
		task check_result(outcome_t got);
			outcome_t ex;
			if (awaited.size() == 0) begin
				report($sformatf("result word with nothing owed, status %0d size %0d",
					got.status, got.size));
				return;
			end
			ex = awaited.pop_front();
			if (got.status !== ex.status)
				report($sformatf("status %0d, want %0d", got.status, ex.status));
			if (got.value !== ex.value)
				report($sformatf("value_out %h, want %h", got.value, ex.value));
			if (got.found !== ex.found)
				report($sformatf("found_at %h, want %h", got.found, ex.found));
			if (got.size !== ex.size)
				report($sformatf("size_out %0d, want %0d", got.size, ex.size));
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;   // position_in, run_length, value_in, zero fill
	logic [ACTION_W-1:0] s_tuser = '0;     // action
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;       // value_out, found_at, size_out, zero fill
	logic [STATUS_W-1:0] m_tuser;          // status

	list_tracker ledger = new();

	array_list_engine_core #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic request_t compose(logic [ACTION_W-1:0] action, int position, int run,
		logic [WORD_W-1:0] value);
		request_t rq;
		rq.action = action;
		rq.position = FIELD_W'(position);
		rq.run = FIELD_W'(run);
		rq.value = value;
		return rq;
	endfunction

	// value mix: the two extremes, a narrow band that makes duplicates, and anything
	function automatic logic [WORD_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3, 4: return WORD_W'($urandom_range(0, 6) - 3);
			default: return WORD_W'($urandom);
		endcase
	endfunction

	// one random request shaped by the drift and the current fill count
	function automatic request_t make_request(drift_t drift);
		request_t rq;
		int cut[5];
		int n, roll, p, lim;
		n = ledger.words.size();
		roll = $urandom_range(0, 99);
		case (drift)
			GROWING: cut = '{45, 80, 88, 93, 96};
			SHRINKING: cut = '{8, 12, 47, 77, 92};
			default: cut = '{20, 40, 55, 65, 85};
		endcase
		rq = compose(ACT_SEARCH, $urandom, $urandom, pick_value());
		if (roll < cut[0]) begin
			rq.action = ACT_APPEND;
		end else if (roll < cut[1]) begin
			rq.action = ACT_INSERT;
			rq.position = FIELD_W'($urandom_range(0, n));
		end else if (roll < cut[2]) begin
			rq.action = ACT_EXTRACT;
			rq.position = (n > 0) ? FIELD_W'($urandom_range(0, n - 1)) : '0;
		end else if (roll < cut[3]) begin
			// mostly short runs, now and then anything up to the tail
			rq.action = ACT_DELETE;
			p = $urandom_range(0, n);
			lim = ($urandom_range(0, 3) != 0 && n - p > 4) ? 4 : n - p;
			rq.position = FIELD_W'(p);
			rq.run = FIELD_W'($urandom_range(0, lim));
		end else if (roll < cut[4]) begin
			// half the searches look for a word that is stored
			if (n > 0 && $urandom_range(0, 1))
				rq.value = ledger.words[$urandom_range(0, n - 1)];
		end else begin
			// rejected requests: bad index, bad range or a spare action
			case ($urandom_range(0, 3))
				0: begin
					rq.action = ACT_INSERT;
					rq.position = FIELD_W'($urandom_range(n + 1, FIELD_TOP));
				end
				1: begin
					rq.action = ACT_EXTRACT;
					rq.position = FIELD_W'($urandom_range(n, FIELD_TOP));
				end
				2: begin
					rq.action = ACT_DELETE;
					if ($urandom_range(0, 1)) begin
						rq.position = FIELD_W'($urandom_range(n + 1, FIELD_TOP));
					end else begin
						p = $urandom_range(0, n);
						rq.position = FIELD_W'(p);
						rq.run = FIELD_W'($urandom_range(n - p + 1, FIELD_TOP));
					end
				end
				default: rq.action = ACT_SPARE_HI - ACTION_W'($urandom_range(0, 2));
			endcase
		end
		return rq;
	endfunction

	// present one request word, with random idle cycles ahead of it unless steady
	task automatic offer(input request_t rq, input bit steady);
		while (!steady && $urandom_range(0, 99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'({rq.value, rq.run, rq.position});
		s_tuser <= rq.action;
		do @(posedge clk); while (!s_tready);
		ledger.note_request(rq);
	endtask

	// sender: reset, directed words, then random words in growing, shrinking and wandering phases
	initial begin
		request_t plan[DIRECTED_WORDS];
		drift_t drift;
		int k, n, top_visits;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = '{
			compose(ACT_SEARCH, 0, 0, 32'h0),              // search on an empty list
			compose(ACT_EXTRACT, 0, 0, 32'h0),             // extract from an empty list
			compose(ACT_DELETE, 0, 0, 32'h0),              // empty run on an empty list
			compose(ACT_DELETE, 0, 1, 32'h0),              // run past the end
			compose(ACT_INSERT, 1, 0, 32'h1),              // insert past the end
			compose(ACT_INSERT, 0, 0, 32'h8000_0000),      // insert at the head
			compose(ACT_APPEND, 0, 0, 32'h7fff_ffff),
			compose(ACT_APPEND, 0, 0, 32'hffff_ffff),
			compose(ACT_APPEND, 0, 0, 32'h0),
			compose(ACT_INSERT, 4, 0, 32'h5),              // insert right at the fill count
			compose(ACT_INSERT, 2, 0, 32'h7fff_ffff),      // duplicate in the middle
			compose(ACT_SEARCH, 0, 0, 32'h7fff_ffff),      // first of two copies
			compose(ACT_SEARCH, 0, 0, 32'h5),              // last entry
			compose(ACT_EXTRACT, FIELD_TOP, 0, 32'h0),     // widest bad index
			compose(ACT_INSERT, FIELD_TOP, 0, 32'h9),
			compose(ACT_DELETE, FIELD_TOP, FIELD_TOP, 32'h0),
			compose(ACT_DELETE, 2, 5, 32'h0),              // run one longer than the tail
			compose(ACT_SPARE_LO, FIELD_TOP, FIELD_TOP, 32'hffff_ffff),
			compose(ACT_SPARE_HI, 0, 0, 32'h0),
			compose(ACT_EXTRACT, 5, 0, 32'h0),             // extract the last entry
			compose(ACT_EXTRACT, 0, 0, 32'h0),             // extract the head
			compose(ACT_DELETE, 1, 2, 32'h0),
			compose(ACT_DELETE, 2, 0, 32'h0),              // empty run at the fill count
			compose(ACT_DELETE, 0, 2, 32'h0),              // clear what is left
			compose(ACT_SEARCH, 0, 0, 32'hffff_ffff)
		};
		for (k = 0; k < DIRECTED_WORDS; k++)
			offer(plan[k], 1'b0);

		drift = GROWING;
		top_visits = 0;
		for (k = 0; k < RANDOM_WORDS; k++) begin
			n = ledger.words.size();
			// stay at the top long enough to hit the full cases, then drain
			if (drift == GROWING && n == DEPTH) begin
				top_visits++;
				if (top_visits > 10) begin
					drift = SHRINKING;
					top_visits = 0;
				end
			end else if (drift == SHRINKING && n == 0) begin
				drift = $urandom_range(0, 1) ? GROWING : WANDERING;
			end else if (drift == WANDERING && $urandom_range(0, 99) == 0) begin
				drift = GROWING;
			end
			// one pause until the block has answered everything
			if (k == 700) begin
				while (ledger.awaited.size() != 0) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
				end
			end
			offer(make_request(drift), k >= 1000 && k < 1300);
		end
		s_tvalid <= 1'b0;

		while (ledger.awaited.size() != 0) @(posedge clk);
		// let any stray result word show up before the verdict
		repeat (DEPTH + 8) @(posedge clk);
		if (ledger.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// receiver: checks every result word, stalls at random and twice holds off for long
	initial begin
		outcome_t got;
		int seen, hold_left;
		seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.value = m_tdata[31:0];
				got.found = m_tdata[40:32];
				got.size = m_tdata[49:41];
				ledger.check_result(got);
				seen++;
				// long hold so the output register fills and the input stalls
				if (seen == 60 || seen == 900)
					hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (seen >= 300 && seen < 600) || ($urandom_range(0, 99) >= 19);
			end
		end
	end

	// hang guard
	initial begin
		#(RUN_LIMIT);
		$display("Some tests failed");
		$finish;
	end

endmodule
